@@ hw/rtl/assert_macros.svh @@
// assertion macros shared by the keyed list rtl
// expects a clock named clk and an active-low reset named arst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define KDL_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// expression must never be true outside reset
`define KDL_ASSERT_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);

`endif

@@ hw/rtl/kdl_pkg.sv @@
// shared types and constants of the keyed doubly linked list
// used by kdl_ctrl, kdl_dp and the top level; depends on nothing
`default_nettype none

package kdl_pkg;

	localparam int KEY_W     = 10;
	localparam int KEY_SPACE = 1 << KEY_W;
	localparam int CNT_W     = KEY_W;
	localparam int ACT_W     = 3;
	localparam int STAT_W    = 2;

	typedef logic [KEY_W-1:0]  key_t;
	typedef logic [CNT_W-1:0]  cnt_t;
	typedef logic [ACT_W-1:0]  act_t;
	typedef logic [STAT_W-1:0] stat_code_t;

	// action codes
	localparam act_t ACT_APPEND    = 3'd0;
	localparam act_t ACT_INS_LEFT  = 3'd1;
	localparam act_t ACT_INS_RIGHT = 3'd2;
	localparam act_t ACT_DELETE    = 3'd3;
	localparam act_t ACT_READ      = 3'd4;

	// status codes
	localparam stat_code_t ST_OK          = 2'd0;
	localparam stat_code_t ST_ANCHOR_ABS  = 2'd1;
	localparam stat_code_t ST_NEW_PRESENT = 2'd2;
	localparam stat_code_t ST_TARGET_ABS  = 2'd3;

	// controller states
	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_RD1,
		S_RD2,
		S_EVAL,
		S_WR1,
		S_WR2,
		S_RESP
	} state_t;

	// commands from controller to datapath
	typedef struct packed {
		logic capture;
		logic clr_wr;
		logic rd_key;
		logic rd_nk;
		logic eval;
		logic wr1;
		logic wr2;
		logic load_out;
	} cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic clr_done;
		logic do_insert;
		logic do_delete;
	} dp_stat_t;

endpackage

`default_nettype wire

@@ hw/rtl/kdl_ram.sv @@
// generic single-port-write, single-port-read ram with registered read
// no dependencies
`default_nettype none

module kdl_ram #(
	parameter int Width = 10,
	parameter int Depth = 1024,
	localparam int AddrW = $clog2(Depth)
) (
	input  wire logic             clk,
	input  wire logic             wr_en,
	input  wire logic [AddrW-1:0] wr_addr,
	input  wire logic [Width-1:0] wr_data,
	input  wire logic             rd_en,
	input  wire logic [AddrW-1:0] rd_addr,
	output logic      [Width-1:0] rd_data
);

	logic [Width-1:0] mem_q [Depth];
	logic [Width-1:0] rd_data_q;

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

@@ hw/rtl/kdl_ctrl.sv @@
// controller state machine of the keyed doubly linked list
// depends on kdl_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module kdl_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_tvalid,
	output logic                   in_tready,
	output logic                   out_tvalid,
	input  wire logic              out_tready,
	input  wire kdl_pkg::dp_stat_t stat,
	output kdl_pkg::cmd_t          cmd
);

	kdl_pkg::state_t state_q, state_d;
	logic out_valid_q;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= kdl_pkg::S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		in_tready = 1'b0;
		case (state_q)
			kdl_pkg::S_CLEAR: begin
				cmd.clr_wr = 1'b1;
				if (stat.clr_done) begin
					state_d = kdl_pkg::S_IDLE;
				end
			end
			kdl_pkg::S_IDLE: begin
				in_tready = 1'b1;
				if (in_tvalid) begin
					cmd.capture = 1'b1;
					state_d     = kdl_pkg::S_RD1;
				end
			end
			kdl_pkg::S_RD1: begin
				cmd.rd_key = 1'b1;
				state_d    = kdl_pkg::S_RD2;
			end
			kdl_pkg::S_RD2: begin
				cmd.rd_nk = 1'b1;
				state_d   = kdl_pkg::S_EVAL;
			end
			kdl_pkg::S_EVAL: begin
				cmd.eval = 1'b1;
				if (stat.do_insert) begin
					state_d = kdl_pkg::S_WR1;
				end else if (stat.do_delete) begin
					state_d = kdl_pkg::S_WR2;
				end else begin
					state_d = kdl_pkg::S_RESP;
				end
			end
			kdl_pkg::S_WR1: begin
				cmd.wr1 = 1'b1;
				state_d = kdl_pkg::S_WR2;
			end
			kdl_pkg::S_WR2: begin
				cmd.wr2 = 1'b1;
				state_d = kdl_pkg::S_RESP;
			end
			kdl_pkg::S_RESP: begin
				if (!out_valid_q || out_tready) begin
					cmd.load_out = 1'b1;
					state_d      = kdl_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = kdl_pkg::S_IDLE;
			end
		endcase
	end

	// result slot valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_tvalid = out_valid_q;

	`KDL_ASSERT_NEVER(a_cmd_onehot, !$onehot0(cmd), "more than one datapath command at once")
	`KDL_ASSERT(a_load_free, cmd.load_out |-> (!out_valid_q || out_tready), "result slot overwritten")
	`KDL_ASSERT_NEVER(a_no_dual_op, cmd.eval && stat.do_insert && stat.do_delete, "insert and delete both chosen")

endmodule

`default_nettype wire

@@ hw/rtl/kdl_dp.sv @@
// datapath of the keyed doubly linked list: link tables, marks, head, tail, count
// depends on kdl_pkg, kdl_ram and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module kdl_dp (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire kdl_pkg::cmd_t       cmd,
	output kdl_pkg::dp_stat_t        stat,
	input  wire kdl_pkg::act_t       action,
	input  wire kdl_pkg::key_t       key,
	input  wire kdl_pkg::key_t       new_key,
	output kdl_pkg::stat_code_t      status,
	output kdl_pkg::key_t            next_key,
	output logic                     at_end,
	output kdl_pkg::cnt_t            entry_count
);

	// captured item
	kdl_pkg::act_t act_q;
	kdl_pkg::key_t key_q;
	kdl_pkg::key_t nk_q;

	// list registers
	kdl_pkg::key_t first_q;
	kdl_pkg::key_t last_q;
	kdl_pkg::cnt_t count_q;
	kdl_pkg::key_t clr_q;

	// evaluation results
	logic                pres_key_q;
	kdl_pkg::key_t       left_q;
	kdl_pkg::key_t       right_q;
	kdl_pkg::stat_code_t res_status_q;
	kdl_pkg::key_t       res_next_q;
	logic                res_end_q;

	// result slot
	kdl_pkg::stat_code_t out_status_q;
	kdl_pkg::key_t       out_next_q;
	logic                out_end_q;
	kdl_pkg::cnt_t       out_count_q;

	// ram ports
	logic          pred_we, succ_we, pres_we;
	kdl_pkg::key_t pred_wa, succ_wa, pres_wa;
	kdl_pkg::key_t pred_wd, succ_wd;
	logic          pres_wd;
	kdl_pkg::key_t pres_ra;
	kdl_pkg::key_t pred_rd, succ_rd;
	logic          pres_rd;

	// evaluation logic
	logic                is_ins, is_ins_q, anchor_zero, anchor_ok, nk_bad, read_ok;
	kdl_pkg::key_t       anchor, prv_a, nxt_a, left_d, right_d;
	kdl_pkg::key_t       link_l, link_r;
	kdl_pkg::stat_code_t status_d;

	// capture the accepted item
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			act_q <= action;
			key_q <= key;
			nk_q  <= new_key;
		end
	end

	// neighbor and status evaluation
	always_comb begin
		is_ins      = (act_q == kdl_pkg::ACT_APPEND) || (act_q == kdl_pkg::ACT_INS_LEFT) ||
		              (act_q == kdl_pkg::ACT_INS_RIGHT);
		anchor_zero = (act_q == kdl_pkg::ACT_APPEND) || (key_q == '0);
		anchor      = anchor_zero ? '0 : key_q;
		anchor_ok   = anchor_zero || pres_key_q;
		nk_bad      = (nk_q == '0) || pres_rd;
		prv_a       = anchor_zero ? last_q : pred_rd;
		nxt_a       = anchor_zero ? first_q : succ_rd;
		read_ok     = (key_q == '0) || pres_key_q;
		left_d      = (act_q == kdl_pkg::ACT_INS_RIGHT) ? anchor : prv_a;
		right_d     = ((act_q == kdl_pkg::ACT_INS_RIGHT) || (act_q == kdl_pkg::ACT_DELETE)) ?
		              nxt_a : anchor;
		stat.clr_done  = (clr_q == '1);
		stat.do_insert = is_ins && anchor_ok && !nk_bad;
		stat.do_delete = (act_q == kdl_pkg::ACT_DELETE) && (key_q != '0) && pres_key_q;
		case (act_q)
			kdl_pkg::ACT_APPEND, kdl_pkg::ACT_INS_LEFT, kdl_pkg::ACT_INS_RIGHT: begin
				if (!anchor_ok) begin
					status_d = kdl_pkg::ST_ANCHOR_ABS;
				end else if (nk_bad) begin
					status_d = kdl_pkg::ST_NEW_PRESENT;
				end else begin
					status_d = kdl_pkg::ST_OK;
				end
			end
			kdl_pkg::ACT_DELETE: begin
				status_d = stat.do_delete ? kdl_pkg::ST_OK : kdl_pkg::ST_TARGET_ABS;
			end
			kdl_pkg::ACT_READ: begin
				status_d = read_ok ? kdl_pkg::ST_OK : kdl_pkg::ST_TARGET_ABS;
			end
			default: begin
				status_d = kdl_pkg::ST_OK;
			end
		endcase
	end

	// present mark of the key, then evaluation results
	always_ff @(posedge clk) begin
		if (cmd.rd_nk) begin
			pres_key_q <= pres_rd;
		end
		if (cmd.eval) begin
			left_q       <= left_d;
			right_q      <= right_d;
			is_ins_q     <= is_ins;
			res_status_q <= status_d;
			res_next_q   <= ((act_q == kdl_pkg::ACT_READ) && read_ok) ? nxt_a : '0;
			res_end_q    <= (act_q == kdl_pkg::ACT_READ) && read_ok && (nxt_a == '0);
		end
	end

	// new links: insert points both neighbors at the new key, delete joins them
	assign link_l = is_ins_q ? nk_q : right_q;
	assign link_r = is_ins_q ? nk_q : left_q;

	// table write ports
	always_comb begin
		succ_we = 1'b0;
		succ_wa = nk_q;
		succ_wd = right_q;
		pred_we = 1'b0;
		pred_wa = nk_q;
		pred_wd = left_q;
		pres_we = 1'b0;
		pres_wa = clr_q;
		pres_wd = 1'b0;
		if (cmd.clr_wr) begin
			pres_we = 1'b1;
		end
		if (cmd.wr1) begin
			succ_we = 1'b1;
			pred_we = 1'b1;
		end
		if (cmd.wr2) begin
			succ_we = (left_q != '0);
			succ_wa = left_q;
			succ_wd = link_l;
			pred_we = (right_q != '0);
			pred_wa = right_q;
			pred_wd = link_r;
			pres_we = 1'b1;
			pres_wa = is_ins_q ? nk_q : key_q;
			pres_wd = is_ins_q;
		end
	end

	assign pres_ra = cmd.rd_nk ? nk_q : key_q;

	// head, tail, count and clearing pass counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q <= '0;
			last_q  <= '0;
			count_q <= '0;
			clr_q   <= '0;
		end else begin
			if (cmd.clr_wr) begin
				clr_q <= clr_q + kdl_pkg::KEY_W'(1);
			end
			if (cmd.wr2) begin
				if (left_q == '0) begin
					first_q <= link_l;
				end
				if (right_q == '0) begin
					last_q <= link_r;
				end
				count_q <= is_ins_q ? count_q + kdl_pkg::CNT_W'(1) :
				                      count_q - kdl_pkg::CNT_W'(1);
			end
		end
	end

	// result slot
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_status_q <= res_status_q;
			out_next_q   <= res_next_q;
			out_end_q    <= res_end_q;
			out_count_q  <= count_q;
		end
	end

	assign status      = out_status_q;
	assign next_key    = out_next_q;
	assign at_end      = out_end_q;
	assign entry_count = out_count_q;

	kdl_ram #(.Width(kdl_pkg::KEY_W), .Depth(kdl_pkg::KEY_SPACE)) u_pred (
		.clk     (clk),
		.wr_en   (pred_we),
		.wr_addr (pred_wa),
		.wr_data (pred_wd),
		.rd_en   (cmd.rd_key),
		.rd_addr (key_q),
		.rd_data (pred_rd)
	);

	kdl_ram #(.Width(kdl_pkg::KEY_W), .Depth(kdl_pkg::KEY_SPACE)) u_succ (
		.clk     (clk),
		.wr_en   (succ_we),
		.wr_addr (succ_wa),
		.wr_data (succ_wd),
		.rd_en   (cmd.rd_key),
		.rd_addr (key_q),
		.rd_data (succ_rd)
	);

	kdl_ram #(.Width(1), .Depth(kdl_pkg::KEY_SPACE)) u_pres (
		.clk     (clk),
		.wr_en   (pres_we),
		.wr_addr (pres_wa),
		.wr_data (pres_wd),
		.rd_en   (cmd.rd_key || cmd.rd_nk),
		.rd_addr (pres_ra),
		.rd_data (pres_rd)
	);

	`KDL_ASSERT(a_count_inc, (cmd.wr2 && is_ins_q) |=> (count_q == $past(count_q) + kdl_pkg::CNT_W'(1)), "count not incremented on insert")
	`KDL_ASSERT(a_empty_ends, (count_q == '0) |-> ((first_q == '0) && (last_q == '0)), "empty list with head or tail set")
	`KDL_ASSERT_NEVER(a_clear_busy, cmd.clr_wr && (cmd.wr1 || cmd.wr2), "table write during clearing pass")

endmodule

`default_nettype wire

@@ hw/rtl/keyed_doubly_linked_list.sv @@
// Keyed doubly linked list, top level: streaming ports around kdl_ctrl and kdl_dp.
// One item is handled at a time, as s_axis_tready is high only in idle; each item walks
// the read, evaluate and write states (WR1 for append and insert, WR2 for insert and
// delete) on link tables with one read and one write port, then loads the result slot once it is free.
// Reset empties the list; a clearing pass over the present marks
// follows reset, with s_axis_tready low throughout.
`default_nettype none

module keyed_doubly_linked_list (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [23:0] s_axis_tdata,   // action[2:0], key[12:3], new_key[22:13]
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic      [23:0] m_axis_tdata    // status[1:0], next_key[11:2], at_end[12], entry_count[22:13]
);

	kdl_pkg::cmd_t       cmd;
	kdl_pkg::dp_stat_t   stat;
	kdl_pkg::stat_code_t status;
	kdl_pkg::key_t       next_key;
	logic                at_end;
	kdl_pkg::cnt_t       entry_count;

	kdl_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_tvalid  (s_axis_tvalid),
		.in_tready  (s_axis_tready),
		.out_tvalid (m_axis_tvalid),
		.out_tready (m_axis_tready),
		.stat       (stat),
		.cmd        (cmd)
	);

	kdl_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.action      (s_axis_tdata[2:0]),
		.key         (s_axis_tdata[12:3]),
		.new_key     (s_axis_tdata[22:13]),
		.status      (status),
		.next_key    (next_key),
		.at_end      (at_end),
		.entry_count (entry_count)
	);

	// pack result item
	assign m_axis_tdata = {1'b0, entry_count, at_end, next_key, status};

endmodule

`default_nettype wire
